// File: rtl/dlt_pkg.sv
// shared types, constants and helper functions of the longest-match tokenizer
package dlt_pkg;

  localparam int STATE_COUNT    = 64;
  localparam int TAG_COUNT      = 16;
  localparam int LOOKBACK_DEPTH = 16;
  localparam int POSITION_BITS  = 24;
  localparam int LINE_BITS      = 24;

  localparam int STATE_BITS = $clog2(STATE_COUNT);
  localparam int TAG_BITS   = $clog2(TAG_COUNT);
  localparam int TRANS_ADDR_BITS = STATE_BITS + 8;
  localparam int TRANS_DEPTH = STATE_COUNT * 256;
  localparam int TRANS_BITS  = STATE_BITS + 1;
  // queue holds the lookback bytes plus the byte being scanned, with wrap room
  localparam int QUEUE_BITS  = $clog2(2 * (LOOKBACK_DEPTH + 1));
  localparam int QUEUE_DEPTH = 1 << QUEUE_BITS;
  localparam int NL_BITS     = $clog2(LOOKBACK_DEPTH + 2);

  localparam logic [POSITION_BITS-1:0] POS_MAX  = '1;
  localparam logic [LINE_BITS-1:0]     LINE_MAX = '1;
  localparam logic [LINE_BITS-1:0]     LINE_ONE = LINE_BITS'(1);

  localparam logic [7:0] CH_NL = 8'h0a;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_HT = 8'h09;
  localparam logic [7:0] CH_FF = 8'h0c;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_VT = 8'h0b;

  typedef enum logic [1:0] {
    MODE_LOAD_TRANS = 2'd0,
    MODE_LOAD_TAG   = 2'd1,
    MODE_TEXT       = 2'd2,
    MODE_END        = 2'd3
  } mode_t;

  localparam logic KIND_TOKEN = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_TRANS,
    ST_TAG,
    ST_FIN,
    ST_END
  } seq_state_t;

  typedef struct packed {
    mode_t       mode;
    logic [5:0]  state_index;
    logic [7:0]  byte_value;
    logic [5:0]  next_state;
    logic        next_valid;
    logic [3:0]  tag_value;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [23:0] token_first;
    logic [23:0] token_after;
    logic [3:0]  token_tag;
    logic [23:0] line_number;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic                 en;
    logic [STATE_BITS-1:0] addr;
    logic [TAG_BITS-1:0]   tag;
  } tag_wr_t;

  function automatic logic [POSITION_BITS-1:0] pos_inc(input logic [POSITION_BITS-1:0] p);
    pos_inc = (p == POS_MAX) ? POS_MAX : p + POSITION_BITS'(1);
  endfunction

  function automatic logic [LINE_BITS-1:0] line_add(input logic [LINE_BITS-1:0] a,
                                                    input logic [NL_BITS-1:0] b);
    logic [LINE_BITS:0] s;
    s = {1'b0, a} + (LINE_BITS + 1)'(b);
    line_add = s[LINE_BITS] ? LINE_MAX : s[LINE_BITS-1:0];
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    is_blank = (b == CH_SP) || (b == CH_HT) || (b == CH_FF) || (b == CH_CR) ||
               (b == CH_VT) || (b == CH_NL);
  endfunction

endpackage

// File: rtl/dlt_trans_ram.sv
// transition table memory, one write port and one registered read port
module dlt_trans_ram
  import dlt_pkg::*;
(
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [TRANS_ADDR_BITS-1:0] wr_addr,
  input  logic [TRANS_BITS-1:0]      wr_data,
  input  logic                       rd_en,
  input  logic [TRANS_ADDR_BITS-1:0] rd_addr,
  output logic [TRANS_BITS-1:0]      rd_data
);

  logic [TRANS_BITS-1:0] mem [TRANS_DEPTH];
  logic [TRANS_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/dlt_tag_ram.sv
// accepting tag per state, with per-entry valid bits so reset reads as zero
module dlt_tag_ram
  import dlt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  tag_wr_t               wr,
  input  logic                  rd_en,
  input  logic [STATE_BITS-1:0] rd_addr,
  output logic [TAG_BITS-1:0]   rd_tag
);

  logic [TAG_BITS-1:0]    mem [STATE_COUNT];
  logic [STATE_COUNT-1:0] valid_r;
  logic [TAG_BITS-1:0]    rd_mem_r;
  logic                   rd_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.tag;
    end
    if (rd_en) begin
      rd_mem_r <= mem[rd_addr];
    end
  end

  assign rd_tag = rd_vld_r ? rd_mem_r : '0;

endmodule

// File: rtl/dfa_longest_match_tokenizer.sv
// top level: byte queue, scan sequencer and result staging of the tokenizer
//
//   channel  direction  payload      handshake
//   in_      input      in_item_t    in_valid / in_ready
//   out_     output     out_item_t   out_valid / out_ready
//
// a load item is taken on acceptance; a text item is accepted, then each scanned
// byte passes queue fetch, transition read and tag read, a dead byte passes fetch
// and transition read before its replay and a skipped blank passes fetch alone; an
// empty-queue check and a result close end the item; replayed bytes go the same way
// end of text flushes the pending token and replays its lookback the same way
// results pass through a one-deep hold stage and an output register; a stalled
// output stops the sequencer only when both are full
// reset clears control state and the tag valid bits; the transition table is
// not cleared
module dfa_longest_match_tokenizer
  import dlt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  seq_state_t state_r, state_nxt;

  logic [7:0]            qbuf_r [QUEUE_DEPTH];
  logic [7:0]            q_byte_r;
  logic [QUEUE_BITS-1:0] rd_r, rd_nxt, wr_r, wr_nxt, base_r, base_nxt;
  logic [NL_BITS-1:0]    nl_r, nl_nxt;
  logic [STATE_BITS-1:0] dfa_r, dfa_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt, start_r, start_nxt, aend_r, aend_nxt;
  logic [LINE_BITS-1:0]  line_r, line_nxt;
  logic [TAG_BITS-1:0]   atag_r, atag_nxt;
  logic                  in_tok_r, in_tok_nxt, halted_r, halted_nxt, fin_r, fin_nxt;
  logic [7:0]            byte_r, byte_nxt;
  out_item_t             hold_r, hold_nxt, out_r, out_nxt;
  logic                  hold_vld_r, hold_vld_nxt, out_vld_r, out_vld_nxt;

  logic                  in_acc;
  logic                  q_wr;
  logic [7:0]            q_byte;
  logic [QUEUE_BITS-1:0] fill;
  logic                  can_emit, emit_req;
  out_item_t             emit_rec;

  logic                       tr_wr_en, tr_rd_en;
  logic [TRANS_ADDR_BITS-1:0] tr_rd_addr;
  logic [TRANS_BITS-1:0]      tr_rd_data;
  tag_wr_t                    tag_wr;
  logic                       tag_rd_en;
  logic [STATE_BITS-1:0]      tag_rd_addr;
  logic [TAG_BITS-1:0]        tag_rd;
  logic [STATE_BITS-1:0]      scan_st;
  logic                       is_nl;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  assign tr_wr_en   = in_acc && !halted_r && (in_data.mode == MODE_LOAD_TRANS);
  assign tag_wr.en   = in_acc && !halted_r && (in_data.mode == MODE_LOAD_TAG);
  assign tag_wr.addr = in_data.state_index;
  assign tag_wr.tag  = in_data.tag_value;

  dlt_trans_ram u_trans_ram (
    .clk     (clk),
    .wr_en   (tr_wr_en),
    .wr_addr ({in_data.state_index, in_data.byte_value}),
    .wr_data (in_data.next_valid ? {1'b1, in_data.next_state} : '0),
    .rd_en   (tr_rd_en),
    .rd_addr (tr_rd_addr),
    .rd_data (tr_rd_data)
  );

  dlt_tag_ram u_tag_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (tag_wr),
    .rd_en   (tag_rd_en),
    .rd_addr (tag_rd_addr),
    .rd_tag  (tag_rd)
  );

  // registered queue read, always holding the byte at the read pointer
  assign q_byte  = q_byte_r;
  assign fill    = rd_r - base_r;
  assign can_emit = !hold_vld_r || !out_vld_r || out_ready;
  assign scan_st = in_tok_r ? dfa_r : '0;
  assign tr_rd_addr = {scan_st, q_byte};
  assign tag_rd_addr = tr_rd_data[STATE_BITS-1:0];
  assign is_nl = (byte_r == CH_NL);

  always_comb begin
    state_nxt    = state_r;
    rd_nxt       = rd_r;
    wr_nxt       = wr_r;
    base_nxt     = base_r;
    nl_nxt       = nl_r;
    dfa_nxt      = dfa_r;
    pos_nxt      = pos_r;
    start_nxt    = start_r;
    aend_nxt     = aend_r;
    line_nxt     = line_r;
    atag_nxt     = atag_r;
    in_tok_nxt   = in_tok_r;
    halted_nxt   = halted_r;
    fin_nxt      = fin_r;
    byte_nxt     = byte_r;
    hold_nxt     = hold_r;
    hold_vld_nxt = hold_vld_r;
    out_nxt      = out_r;
    out_vld_nxt  = out_vld_r && !out_ready;
    q_wr         = 1'b0;
    tr_rd_en     = 1'b0;
    tag_rd_en    = 1'b0;
    emit_req     = 1'b0;
    emit_rec     = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc && !halted_r) begin
          case (in_data.mode)
            MODE_TEXT: begin
              q_wr      = 1'b1;
              wr_nxt    = wr_r + QUEUE_BITS'(1);
              fin_nxt   = 1'b0;
              state_nxt = ST_FETCH;
            end
            MODE_END: begin
              fin_nxt   = 1'b1;
              state_nxt = ST_FIN;
            end
            default: begin
            end
          endcase
        end
      end

      ST_FETCH: begin
        if (rd_r == wr_r) begin
          state_nxt = fin_r ? ST_FIN : ST_END;
        end else if (!in_tok_r && is_blank(q_byte)) begin
          if (q_byte == CH_NL) begin
            line_nxt = line_add(line_r, NL_BITS'(1));
          end
          pos_nxt  = pos_inc(pos_r);
          rd_nxt   = rd_r + QUEUE_BITS'(1);
          base_nxt = rd_r + QUEUE_BITS'(1);
        end else begin
          if (!in_tok_r) begin
            in_tok_nxt = 1'b1;
            start_nxt  = pos_r;
            atag_nxt   = '0;
            dfa_nxt    = '0;
            base_nxt   = rd_r;
            nl_nxt     = '0;
          end
          byte_nxt  = q_byte;
          tr_rd_en  = 1'b1;
          state_nxt = ST_TRANS;
        end
      end

      ST_TRANS: begin
        if (tr_rd_data[TRANS_BITS-1]) begin
          dfa_nxt   = tr_rd_data[STATE_BITS-1:0];
          tag_rd_en = 1'b1;
          state_nxt = ST_TAG;
        end else if (can_emit) begin
          emit_req = 1'b1;
          if (atag_r == '0 || fill >= QUEUE_BITS'(LOOKBACK_DEPTH)) begin
            emit_rec.kind        = KIND_ERROR;
            emit_rec.token_first = start_r;
            emit_rec.token_after = pos_r;
            emit_rec.line_number = line_add(line_r, nl_r);
            halted_nxt = 1'b1;
            state_nxt  = ST_END;
          end else begin
            emit_rec.kind        = KIND_TOKEN;
            emit_rec.token_first = start_r;
            emit_rec.token_after = aend_r;
            emit_rec.token_tag   = atag_r;
            emit_rec.line_number = line_r;
            // replay from the byte after the accept point
            rd_nxt     = base_r;
            nl_nxt     = '0;
            pos_nxt    = aend_r;
            dfa_nxt    = '0;
            in_tok_nxt = 1'b0;
            atag_nxt   = '0;
            state_nxt  = ST_FETCH;
          end
        end
      end

      ST_TAG: begin
        if (tag_rd != '0) begin
          line_nxt  = line_add(line_r, nl_r + NL_BITS'(is_nl));
          nl_nxt    = '0;
          base_nxt  = rd_r + QUEUE_BITS'(1);
          aend_nxt  = pos_inc(pos_r);
          atag_nxt  = tag_rd;
          rd_nxt    = rd_r + QUEUE_BITS'(1);
          pos_nxt   = pos_inc(pos_r);
          state_nxt = ST_FETCH;
        end else if (fill >= QUEUE_BITS'(LOOKBACK_DEPTH)) begin
          if (can_emit) begin
            emit_req             = 1'b1;
            emit_rec.kind        = KIND_ERROR;
            emit_rec.token_first = start_r;
            emit_rec.token_after = pos_r;
            emit_rec.line_number = line_add(line_r, nl_r);
            halted_nxt = 1'b1;
            state_nxt  = ST_END;
          end
        end else begin
          nl_nxt    = nl_r + NL_BITS'(is_nl);
          rd_nxt    = rd_r + QUEUE_BITS'(1);
          pos_nxt   = pos_inc(pos_r);
          state_nxt = ST_FETCH;
        end
      end

      ST_FIN: begin
        if (halted_r) begin
          state_nxt = ST_END;
        end else if (in_tok_r) begin
          if (can_emit) begin
            emit_req             = 1'b1;
            emit_rec.token_first = start_r;
            if (atag_r == '0) begin
              emit_rec.kind        = KIND_ERROR;
              emit_rec.token_after = pos_r;
              emit_rec.line_number = line_add(line_r, nl_r);
              halted_nxt = 1'b1;
              state_nxt  = ST_END;
            end else begin
              emit_rec.kind        = KIND_TOKEN;
              emit_rec.token_after = aend_r;
              emit_rec.token_tag   = atag_r;
              emit_rec.line_number = line_r;
              rd_nxt     = base_r;
              nl_nxt     = '0;
              pos_nxt    = aend_r;
              dfa_nxt    = '0;
              in_tok_nxt = 1'b0;
              atag_nxt   = '0;
              state_nxt  = ST_FETCH;
            end
          end
        end else begin
          // text finished cleanly: scan state back to its reset values
          pos_nxt   = '0;
          line_nxt  = LINE_ONE;
          start_nxt = '0;
          aend_nxt  = '0;
          atag_nxt  = '0;
          dfa_nxt   = '0;
          base_nxt  = rd_r;
          nl_nxt    = '0;
          fin_nxt   = 1'b0;
          state_nxt = ST_END;
        end
      end

      ST_END: begin
        if (!hold_vld_r) begin
          state_nxt = ST_IDLE;
        end else if (!out_vld_r || out_ready) begin
          out_nxt      = hold_r;
          out_nxt.last = 1'b1;
          out_vld_nxt  = 1'b1;
          hold_vld_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // a new result pushes the held one out; only the final one gets last
    if (emit_req) begin
      if (hold_vld_r) begin
        out_nxt      = hold_r;
        out_nxt.last = 1'b0;
        out_vld_nxt  = 1'b1;
      end
      hold_nxt     = emit_rec;
      hold_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      rd_r       <= '0;
      wr_r       <= '0;
      base_r     <= '0;
      nl_r       <= '0;
      dfa_r      <= '0;
      pos_r      <= '0;
      start_r    <= '0;
      aend_r     <= '0;
      line_r     <= LINE_ONE;
      atag_r     <= '0;
      in_tok_r   <= 1'b0;
      halted_r   <= 1'b0;
      fin_r      <= 1'b0;
      hold_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_r       <= rd_nxt;
      wr_r       <= wr_nxt;
      base_r     <= base_nxt;
      nl_r       <= nl_nxt;
      dfa_r      <= dfa_nxt;
      pos_r      <= pos_nxt;
      start_r    <= start_nxt;
      aend_r     <= aend_nxt;
      line_r     <= line_nxt;
      atag_r     <= atag_nxt;
      in_tok_r   <= in_tok_nxt;
      halted_r   <= halted_nxt;
      fin_r      <= fin_nxt;
      hold_vld_r <= hold_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
    if (q_wr) begin
      qbuf_r[wr_r] <= in_data.byte_value;
    end
    // a byte written now at the next read address is passed straight through
    if (q_wr && (rd_nxt == wr_r)) begin
      q_byte_r <= in_data.byte_value;
    end else begin
      q_byte_r <= qbuf_r[rd_nxt];
    end
  end

endmodule

// File: verif/dfa_longest_match_tokenizer_tb.sv
// self-checking testbench of the longest-match tokenizer: scoreboard and stimulus
`timescale 1ns / 1ps

module dfa_longest_match_tokenizer_tb;
  import dlt_pkg::*;

  // behavior of the tokenizer, kept per accepted item
  class lexer_state;
    bit [6:0]  trans [STATE_COUNT*256];
    bit [3:0]  tags [STATE_COUNT];
    bit [5:0]  cur;
    bit [23:0] pos, line_cnt, first_pos, acc_end;
    bit [3:0]  acc_tag;
    bit [7:0]  rbuf [LOOKBACK_DEPTH];
    int        rfill;
    bit        in_tok, halted;
    out_item_t res[$];

    function new();
      clear_scan();
      halted = 0;
    endfunction

    function void clear_scan();
      cur = 0; pos = 0; line_cnt = 1; first_pos = 0; acc_end = 0; acc_tag = 0;
      rfill = 0; in_tok = 0;
    endfunction

    function bit [23:0] inc(bit [23:0] p);
      return (p == POS_MAX) ? p : p + 24'd1;
    endfunction

    function bit [23:0] add_lines(bit [23:0] a, int b);
      longint s;
      s = longint'(a) + b;
      return (s > longint'(LINE_MAX)) ? LINE_MAX : s[23:0];
    endfunction

    function int held_newlines();
      int n;
      n = 0;
      for (int k = 0; k < rfill; k++) if (rbuf[k] == CH_NL) n++;
      return n;
    endfunction

    function void emit(logic kind, bit [23:0] f, bit [23:0] a, bit [3:0] tg, bit [23:0] ln);
      out_item_t o;
      if (res.size() >= 17) return;
      o.kind = kind; o.token_first = f; o.token_after = a; o.token_tag = tg;
      o.line_number = ln; o.last = 0;
      res.push_back(o);
    endfunction

    function void fail();
      emit(KIND_ERROR, first_pos, pos, 4'd0, add_lines(line_cnt, held_newlines()));
      halted = 1;
    endfunction

    function void emit_rewind();
      emit(KIND_TOKEN, first_pos, acc_end, acc_tag, line_cnt);
      pos = acc_end; cur = 0; in_tok = 0; acc_tag = 0;
    endfunction

    // returns 1 when the scan has to rewind and replay
    function bit scan(bit [7:0] b);
      bit [6:0] e;
      if (!in_tok) begin
        if (is_blank(b)) begin
          if (b == CH_NL) line_cnt = add_lines(line_cnt, 1);
          pos = inc(pos);
          return 0;
        end
        in_tok = 1; first_pos = pos; acc_tag = 0; cur = 0; rfill = 0;
      end
      e = trans[{cur, b}];
      if (e[6]) begin
        cur = e[5:0];
        if (tags[cur] != 0) begin
          line_cnt = add_lines(line_cnt, held_newlines() + (b == CH_NL));
          rfill = 0;
          acc_end = inc(pos);
          acc_tag = tags[cur];
        end else begin
          if (rfill >= LOOKBACK_DEPTH) begin fail(); return 0; end
          rbuf[rfill++] = b;
        end
        pos = inc(pos);
        return 0;
      end
      if (acc_tag == 0 || rfill >= LOOKBACK_DEPTH) begin fail(); return 0; end
      rbuf[rfill++] = b;
      emit_rewind();
      return 1;
    endfunction

    function void drain(bit [7:0] q[$]);
      bit [7:0] t[$];
      int i;
      i = 0;
      while (i < q.size() && !halted) begin
        if (scan(q[i++])) begin
          t = {};
          for (int k = 0; k < rfill; k++) t.push_back(rbuf[k]);
          while (i < q.size() && t.size() < LOOKBACK_DEPTH + 1) t.push_back(q[i++]);
          q = t; i = 0; rfill = 0;
        end
      end
    endfunction

    function void end_text();
      bit [7:0] q[$];
      while (!halted && in_tok) begin
        if (acc_tag == 0) begin fail(); break; end
        q = {};
        for (int k = 0; k < rfill; k++) q.push_back(rbuf[k]);
        rfill = 0;
        emit_rewind();
        drain(q);
      end
      if (!halted) clear_scan();
    endfunction

    function void step(in_item_t it);
      bit [7:0] q[$];
      res.delete();
      if (halted) return;
      case (it.mode)
        MODE_LOAD_TRANS: trans[{it.state_index, it.byte_value}] =
                           it.next_valid ? {1'b1, it.next_state} : 7'd0;
        MODE_LOAD_TAG:   tags[it.state_index] = it.tag_value;
        MODE_TEXT: begin
          q.push_back(it.byte_value);
          drain(q);
        end
        default: end_text();
      endcase
      if (res.size() > 0) res[res.size()-1].last = 1'b1;
    endfunction
  endclass

  class token_scoreboard;
    lexer_state lex;
    out_item_t  awaited[$];
    int errors, tokens, bad_tokens;

    function new();
      lex = new();
    endfunction

    function void note_input(in_item_t it);
      lex.step(it);
      foreach (lex.res[k]) awaited.push_back(lex.res[k]);
    endfunction

    function void field(string n, longint e, longint a);
      if (e != a) begin
        $display("%0t mismatch %s: expected %0d actual %0d", $time, n, e, a);
        errors++;
      end
    endfunction

    function void check_result(out_item_t o);
      out_item_t e;
      if (awaited.size() == 0) begin
        $display("%0t unexpected result: actual %p", $time, o);
        errors++;
        return;
      end
      e = awaited.pop_front();
      field("kind", e.kind, o.kind);
      field("token_first", e.token_first, o.token_first);
      field("token_after", e.token_after, o.token_after);
      field("token_tag", e.token_tag, o.token_tag);
      field("line_number", e.line_number, o.line_number);
      field("last", e.last, o.last);
      if (e.kind == KIND_ERROR) bad_tokens++; else tokens++;
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  dfa_longest_match_tokenizer u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #10 clk = ~clk;

  // text bytes come from this set and CH_Q, so every transition read was loaded
  localparam int ALPHA_N = 12;
  localparam int USED_STATES = 8;
  localparam int IDLE_LIMIT = 3000;
  localparam logic [7:0] ALPHA [ALPHA_N] = '{8'h61, 8'h62, 8'h31, 8'h00, 8'hff, 8'h80,
      CH_SP, CH_HT, CH_NL, CH_CR, CH_VT, CH_FF};
  localparam logic [7:0] CH_Q = 8'h71;

  token_scoreboard sb = new();
  lexer_state      plan = new();
  int tx_idle_pct, rx_stall_pct, sent, idle_cycles;
  bit hold_req, held;
  int hold_left;

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_input(in_data);
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (hold_req && !held) begin
      held = 1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic in_item_t mk(mode_t m, int si, int bv, int ns, bit nv, int tv);
    in_item_t it;
    it.mode = m; it.state_index = 6'(si); it.byte_value = 8'(bv); it.next_state = 6'(ns);
    it.next_valid = nv; it.tag_value = 4'(tv);
    return it;
  endfunction

  // accepts an item for the plan unless it would raise an error and halt
  function automatic bit plan_ok(in_item_t c);
    lexer_state t;
    t = new plan;
    t.step(c);
    foreach (t.res[k]) if (t.res[k].kind == KIND_ERROR) return 0;
    plan.step(c);
    return 1;
  endfunction

  task automatic offer(in_item_t it);
    if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic offer_safe(in_item_t it);
    in_item_t fix;
    if (plan_ok(it)) begin
      offer(it);
    end else begin
      // steer the current state into an accepting state instead
      fix = mk(MODE_LOAD_TRANS, plan.cur, ALPHA[0], 1, 1'b1, 0);
      void'(plan_ok(fix));
      offer(fix);
    end
  endtask

  function automatic in_item_t rand_item();
    int r, st, tg;
    r = $urandom_range(0, 99);
    if (r < 70) return mk(MODE_TEXT, $urandom_range(0, 63),
                          ALPHA[$urandom_range(0, ALPHA_N-1)], $urandom_range(0, 63),
                          $urandom_range(0, 1), $urandom_range(0, 15));
    if (r < 78) return mk(MODE_END, $urandom_range(0, 63), $urandom_range(0, 255),
                          $urandom_range(0, 63), $urandom_range(0, 1), $urandom_range(0, 15));
    if (r < 90) begin
      if ($urandom_range(0, 1))
        return mk(MODE_LOAD_TRANS, $urandom_range(0, USED_STATES-1),
                  ALPHA[$urandom_range(0, ALPHA_N-1)], $urandom_range(0, USED_STATES-1),
                  $urandom_range(0, 99) < 85, 0);
      // sources outside the used states are never reached
      return mk(MODE_LOAD_TRANS, $urandom_range(USED_STATES + 2, 63), $urandom_range(0, 255),
                $urandom_range(0, 63), $urandom_range(0, 1), $urandom_range(0, 15));
    end
    st = $urandom_range(0, 63);
    tg = $urandom_range(0, 15);
    if (st == 1 && tg == 0) tg = 1;
    return mk(MODE_LOAD_TAG, st, $urandom_range(0, 255), $urandom_range(0, 63),
              $urandom_range(0, 1), tg);
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // dfa over the used states and the byte set; state one always accepts
    for (int s = 0; s < USED_STATES; s++)
      for (int a = 0; a < ALPHA_N; a++)
        offer_safe(mk(MODE_LOAD_TRANS, s, ALPHA[a], $urandom_range(0, USED_STATES-1),
                      $urandom_range(0, 99) < 85, 0));
    offer_safe(mk(MODE_LOAD_TAG, 1, 0, 0, 0, 15));
    for (int s = 2; s < USED_STATES; s++)
      offer_safe(mk(MODE_LOAD_TAG, s, 0, 0, 0, $urandom_range(0, 1) ? $urandom_range(1, 15) : 0));

    // directed: blanks, extreme bytes, end inside and outside a token
    offer_safe(mk(MODE_LOAD_TRANS, 63, 8'hff, 63, 1'b0, 15));
    offer_safe(mk(MODE_LOAD_TAG, 63, 8'h00, 0, 1'b1, 0));
    offer_safe(mk(MODE_LOAD_TAG, 62, 8'hff, 63, 1'b1, 15));
    offer_safe(mk(MODE_END, 0, 0, 0, 0, 0));
    foreach (ALPHA[a]) offer_safe(mk(MODE_TEXT, 0, ALPHA[a], 0, 0, 0));
    offer_safe(mk(MODE_TEXT, 0, 8'h61, 0, 0, 0));
    offer_safe(mk(MODE_TEXT, 0, 8'h62, 0, 0, 0));
    offer_safe(mk(MODE_TEXT, 0, CH_NL, 0, 0, 0));
    offer_safe(mk(MODE_END, 63, 8'hff, 63, 1'b1, 15));
    offer_safe(mk(MODE_END, 0, 0, 0, 0, 0));

    for (int p = 0; p < 4; p++) begin
      tx_idle_pct  = (p == 1) ? 61 : (p == 3) ? 30 : 0;
      rx_stall_pct = (p == 2) ? 61 : (p == 3) ? 30 : 0;
      repeat (65) offer_safe(rand_item());
    end

    // long receiver hold while items keep coming
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_req = 1;
    repeat (50) offer_safe(rand_item());

    // close the text, then overrun the lookback with a non-accepting loop
    offer(mk(MODE_END, 0, 0, 0, 0, 0));
    offer(mk(MODE_LOAD_TRANS, 0, CH_Q, 9, 1'b1, 0));
    offer(mk(MODE_LOAD_TRANS, 9, CH_Q, 9, 1'b1, 0));
    offer(mk(MODE_LOAD_TAG, 9, 0, 0, 0, 0));
    repeat (LOOKBACK_DEPTH + 1) offer(mk(MODE_TEXT, 0, CH_Q, 0, 0, 0));
    // halted now: these are ignored
    offer(mk(MODE_TEXT, 0, 8'h61, 0, 0, 0));
    offer(mk(MODE_END, 0, 0, 0, 0, 0));
    in_valid <= 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("sent %0d items; checked %0d tokens and %0d error results",
             sent, sb.tokens, sb.bad_tokens);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
